// ===== src/utd_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

package utd_pkg;

    // Width of the per-message code unit counter; capacity is clamped to its maximum.
    localparam int COUNT_WIDTH = 16;
    localparam logic [COUNT_WIDTH-1:0] UNIT_MAX = '1;

    // Command queue between decoder and output stage; depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Byte classification limits
    localparam logic [7:0] LEAD_MIN   = 8'hC2;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD_LIMIT = 8'hF5;
    localparam logic [7:0] LEAD_ED    = 8'hED;
    localparam logic [7:0] LEAD_F4    = 8'hF4;
    localparam logic [7:0] TRAIL_A0   = 8'hA0;
    localparam logic [7:0] TRAIL_90   = 8'h90;

    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [5:0]  HI_SURR   = 6'b110110;
    localparam logic [5:0]  LO_SURR   = 6'b110111;

    // Work for the output stage produced by one accepted byte.
    typedef struct packed {
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic [1:0]  n_units;
        logic        has_status;
        logic [1:0]  status;
    } cmd_t;

    // Queue handshake between the stages
    typedef struct packed {
        logic full;
        logic empty;
    } queue_flags_t;

endpackage

// ===== src/utf8_to_utf16_decoder.sv =====
// Top level of the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

// Takes one UTF-8 byte per cycle on the slave stream (tlast on the final byte of a
// message) and produces UTF-16 code units on the master stream, closing each message
// with a status item (tlast high, tuser flags it). The front end decodes one byte per
// cycle and posts its work to a four-entry command queue. The output stage emits one
// item per cycle when the receiver is ready. The items a byte yields are none for a
// lead byte, a middle trail byte or a dropped byte without the end flag, one for a
// completed character, two for a surrogate pair or a character plus status, three
// for a surrogate pair plus status. Input is accepted while the queue has room,
// independent of output backpressure until the queue fills. After an error, bytes
// are dropped up to the end of the message and the status carries the first error.
module utf8_to_utf16_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,      // output_capacity
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] utf8_byte
    input  logic        s_axis_tlast,   // message_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_unit
    output logic [2:0]  m_axis_tuser,   // [0] is_status, [2:1] status_code
    output logic        m_axis_tlast    // last_of_message
);

    logic                  push;
    logic                  pop;
    utd_pkg::cmd_t         push_cmd;
    utd_pkg::cmd_t         head;
    utd_pkg::queue_flags_t q_flags;
    logic                  is_status;
    logic [1:0]            status_code;

    utd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_byte   (s_axis_tdata),
        .in_end    (s_axis_tlast),
        .q_flags   (q_flags),
        .in_ready  (s_axis_tready),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    utd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .flags    (q_flags)
    );

    utd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .flags         (q_flags),
        .pop           (pop),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_unit      (m_axis_tdata),
        .out_is_status (is_status),
        .out_status    (status_code),
        .out_last      (m_axis_tlast)
    );

    assign m_axis_tuser = {status_code, is_status};

endmodule

// ===== src/utd_front.sv =====
// Decoder front end: validates UTF-8 bytes and builds output commands.
`timescale 1ns / 1ps

module utd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic                in_end,
    input  utd_pkg::queue_flags_t q_flags,
    output logic                in_ready,
    output logic                push,
    output utd_pkg::cmd_t       push_cmd
);

    logic [15:0]                      capacity_reg;
    logic [7:0]                       lead_reg, lead_next;
    logic [1:0]                       rem_reg, rem_next;
    logic [20:0]                      acc_reg, acc_next;
    logic [utd_pkg::COUNT_WIDTH-1:0]  units_reg, units_next;
    logic                             drop_reg, drop_next;

    logic [utd_pkg::COUNT_WIDTH-1:0]  cap;
    logic [1:0]                       err;
    logic                             second;
    logic                             four_byte;
    logic [20:0]                      acc_new;
    logic [20:0]                      supp;
    logic                             accept;
    utd_pkg::cmd_t                    cmd;

    assign in_ready = !q_flags.full;
    assign accept   = in_valid && in_ready;
    assign acc_new  = {acc_reg[14:0], in_byte[5:0]};
    assign supp     = acc_new - utd_pkg::SUPP_BASE;

    always_comb
    begin
        if (32'(capacity_reg) > 32'(utd_pkg::UNIT_MAX))
        begin
            cap = utd_pkg::UNIT_MAX;
        end
        else
        begin
            cap = utd_pkg::COUNT_WIDTH'(capacity_reg);
        end
    end

    always_comb
    begin
        lead_next  = lead_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        units_next = units_reg;
        drop_next  = drop_reg;
        err        = utd_pkg::ST_OK;
        cmd        = '0;
        four_byte  = (lead_reg >= utd_pkg::LEAD4_MIN);
        if (lead_reg < utd_pkg::LEAD3_MIN)
        begin
            second = (rem_reg == 2'd1);
        end
        else if (!four_byte)
        begin
            second = (rem_reg == 2'd2);
        end
        else
        begin
            second = (rem_reg == 2'd3);
        end

        if (drop_reg)
        begin
            if (in_end)
            begin
                cmd.has_status = 1'b1;
                cmd.status     = lead_reg[1:0];
                lead_next      = '0;
                rem_next       = '0;
                acc_next       = '0;
                units_next     = '0;
                drop_next      = 1'b0;
            end
        end
        else
        begin
            if (rem_reg == 2'd0)
            begin
                if (units_reg >= cap)
                begin
                    err = utd_pkg::ST_OVERFLOW;
                end
                else if (!in_byte[7])
                begin
                    cmd.unit0   = {8'h00, in_byte};
                    cmd.n_units = 2'd1;
                    units_next  = units_reg + 1'b1;
                end
                else if (in_byte < utd_pkg::LEAD_MIN || in_byte >= utd_pkg::LEAD_LIMIT)
                begin
                    err = utd_pkg::ST_INVALID;
                end
                else
                begin
                    lead_next = in_byte;
                    if (in_byte < utd_pkg::LEAD3_MIN)
                    begin
                        rem_next = 2'd1;
                        acc_next = {16'h0000, in_byte[4:0]};
                    end
                    else if (in_byte < utd_pkg::LEAD4_MIN)
                    begin
                        rem_next = 2'd2;
                        acc_next = {17'h00000, in_byte[3:0]};
                    end
                    else
                    begin
                        rem_next = 2'd3;
                        acc_next = {18'h00000, in_byte[2:0]};
                    end
                end
            end
            else
            begin
                if (in_byte[7:6] != 2'b10)
                begin
                    err = utd_pkg::ST_INVALID;
                end
                else if (second && lead_reg == utd_pkg::LEAD3_MIN && in_byte < utd_pkg::TRAIL_A0)
                begin
                    err = utd_pkg::ST_INVALID;
                end
                else if (second && lead_reg == utd_pkg::LEAD_ED && in_byte >= utd_pkg::TRAIL_A0)
                begin
                    err = utd_pkg::ST_INVALID;
                end
                else if (second && lead_reg == utd_pkg::LEAD4_MIN && in_byte < utd_pkg::TRAIL_90)
                begin
                    err = utd_pkg::ST_INVALID;
                end
                else if (second && lead_reg == utd_pkg::LEAD_F4 && in_byte >= utd_pkg::TRAIL_90)
                begin
                    err = utd_pkg::ST_INVALID;
                end

                if (err == utd_pkg::ST_OK)
                begin
                    acc_next = acc_new;
                    rem_next = rem_reg - 2'd1;
                    if (rem_reg == 2'd1)
                    begin
                        if (four_byte)
                        begin
                            if (({1'b0, units_reg} + 2'd2) > {1'b0, cap})
                            begin
                                err = utd_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                cmd.unit0   = {utd_pkg::HI_SURR, supp[19:10]};
                                cmd.unit1   = {utd_pkg::LO_SURR, supp[9:0]};
                                cmd.n_units = 2'd2;
                                units_next  = units_reg + 2'd2;
                            end
                        end
                        else
                        begin
                            cmd.unit0   = acc_new[15:0];
                            cmd.n_units = 2'd1;
                            units_next  = units_reg + 1'b1;
                        end
                    end
                end
            end

            if (err == utd_pkg::ST_OK && in_end && rem_next != 2'd0)
            begin
                err = utd_pkg::ST_INVALID;
            end

            if (in_end)
            begin
                cmd.has_status = 1'b1;
                cmd.status     = err;
                lead_next      = '0;
                rem_next       = '0;
                acc_next       = '0;
                units_next     = '0;
                drop_next      = 1'b0;
            end
            else if (err != utd_pkg::ST_OK)
            begin
                // hold the first error until the end flag
                drop_next = 1'b1;
                lead_next = {6'b000000, err};
                rem_next  = '0;
                acc_next  = '0;
            end
        end
    end

    assign push     = accept && (cmd.n_units != 2'd0 || cmd.has_status);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= 16'hFFFF;
            lead_reg     <= '0;
            rem_reg      <= '0;
            acc_reg      <= '0;
            units_reg    <= '0;
            drop_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (accept)
            begin
                lead_reg  <= lead_next;
                rem_reg   <= rem_next;
                acc_reg   <= acc_next;
                units_reg <= units_next;
                drop_reg  <= drop_next;
            end
        end
    end

endmodule

// ===== src/utd_queue.sv =====
// Short command queue between the decoder front end and the output stage.
`timescale 1ns / 1ps

module utd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  utd_pkg::cmd_t         push_cmd,
    input  logic                  pop,
    output utd_pkg::cmd_t         head,
    output utd_pkg::queue_flags_t flags
);

    utd_pkg::cmd_t                entry_reg [utd_pkg::QUEUE_DEPTH];
    logic [utd_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [utd_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [utd_pkg::QCNT_W-1:0]   count_reg;
    logic                         do_push;
    logic                         do_pop;

    assign flags.full  = (count_reg == utd_pkg::QCNT_W'(utd_pkg::QUEUE_DEPTH));
    assign flags.empty = (count_reg == '0);
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;
    assign head        = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/utd_back.sv =====
// Output stage: expands queued commands into one result item per cycle while the receiver is ready.
`timescale 1ns / 1ps

module utd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  utd_pkg::cmd_t         head,
    input  utd_pkg::queue_flags_t flags,
    output logic                  pop,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [15:0]           out_unit,
    output logic                  out_is_status,
    output logic [1:0]            out_status,
    output logic                  out_last
);

    logic        valid_reg;
    logic [15:0] unit_reg;
    logic        is_status_reg;
    logic [1:0]  status_reg;
    logic [1:0]  phase_reg;
    logic [1:0]  total;
    logic        load;
    logic        emit;
    logic        last_item;

    assign total     = head.n_units + {1'b0, head.has_status};
    assign load      = !valid_reg || out_ready;
    assign emit      = load && !flags.empty;
    assign last_item = (phase_reg + 2'd1 == total);
    assign pop       = emit && last_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= '0;
        end
        else if (load)
        begin
            valid_reg <= !flags.empty;
            if (emit)
            begin
                // advance within the command, restart once it is drained
                phase_reg <= last_item ? 2'd0 : phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (phase_reg < head.n_units)
            begin
                unit_reg      <= (phase_reg == 2'd0) ? head.unit0 : head.unit1;
                is_status_reg <= 1'b0;
                status_reg    <= utd_pkg::ST_OK;
            end
            else
            begin
                unit_reg      <= '0;
                is_status_reg <= 1'b1;
                status_reg    <= head.status;
            end
        end
    end

    assign out_valid     = valid_reg;
    assign out_unit      = unit_reg;
    assign out_is_status = is_status_reg;
    assign out_status    = status_reg;
    assign out_last      = is_status_reg;

endmodule

// ===== dv/tb.sv =====
// Testbench for the UTF-8 to UTF-16 decoder: random and directed byte streams, scoreboard check.
`timescale 1ns / 1ps

module tb;

    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [15:0] unit_word;
        logic        is_status;
        logic [1:0]  status_code;
        logic        last;
    } out_item_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Bytes waiting to be sent, {message_end, utf8_byte}
    logic [8:0]  byte_queue[$];
    // Predicted output items, oldest first
    out_item_t   pending_units[$];

    int bytes_queued = 0;
    int bytes_taken = 0;
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic byte_accepted = 1'b0;

    // Decoder state mirror
    int          capacity = 65535;
    logic [7:0]  lead_byte;
    logic [1:0]  trail_left;
    logic [20:0] code_acc;
    int          units_out;
    logic        dropping;

    utf8_to_utf16_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    function automatic void expect_item(input logic [15:0] cu, input logic st,
                                        input logic [1:0] code);
        pending_units.push_back('{cu, st, code, st});
    endfunction

    function automatic void clear_message();
        lead_byte  = '0;
        trail_left = '0;
        code_acc   = '0;
        units_out  = 0;
        dropping   = 1'b0;
    endfunction

    function automatic void push_request(input logic [7:0] b, input logic eom);
        byte_queue.push_back({eom, b});
        bytes_queued++;
    endfunction

    // Work out the items one accepted byte causes
    function automatic void decode_byte(input logic [7:0] b, input logic eom);
        logic [1:0]  err;
        logic        second;
        logic [20:0] v;
        int          total;
        int          cap_eff;
        err = utd_pkg::ST_OK;
        cap_eff = (capacity > int'(utd_pkg::UNIT_MAX)) ? int'(utd_pkg::UNIT_MAX) : capacity;
        if (dropping)
        begin
            if (eom)
            begin
                expect_item(16'h0000, 1'b1, lead_byte[1:0]);
                clear_message();
            end
            return;
        end
        if (trail_left == 2'd0)
        begin
            if (units_out >= cap_eff)
                err = utd_pkg::ST_OVERFLOW;
            else if (b < 8'h80)
            begin
                expect_item({8'h00, b}, 1'b0, utd_pkg::ST_OK);
                units_out++;
            end
            else if (b < utd_pkg::LEAD_MIN || b >= utd_pkg::LEAD_LIMIT)
                err = utd_pkg::ST_INVALID;
            else
            begin
                lead_byte = b;
                if (b < utd_pkg::LEAD3_MIN)
                begin
                    trail_left = 2'd1;
                    code_acc   = {16'b0, b[4:0]};
                end
                else if (b < utd_pkg::LEAD4_MIN)
                begin
                    trail_left = 2'd2;
                    code_acc   = {17'b0, b[3:0]};
                end
                else
                begin
                    trail_left = 2'd3;
                    code_acc   = {18'b0, b[2:0]};
                end
            end
        end
        else
        begin
            total  = (lead_byte < utd_pkg::LEAD3_MIN) ? 2 :
                     ((lead_byte < utd_pkg::LEAD4_MIN) ? 3 : 4);
            second = (int'(trail_left) == total - 1);
            if (b[7:6] != 2'b10)
                err = utd_pkg::ST_INVALID;
            else if (second && lead_byte == utd_pkg::LEAD3_MIN && b < utd_pkg::TRAIL_A0)
                err = utd_pkg::ST_INVALID;
            else if (second && lead_byte == utd_pkg::LEAD_ED && b >= utd_pkg::TRAIL_A0)
                err = utd_pkg::ST_INVALID;
            else if (second && lead_byte == utd_pkg::LEAD4_MIN && b < utd_pkg::TRAIL_90)
                err = utd_pkg::ST_INVALID;
            else if (second && lead_byte == utd_pkg::LEAD_F4 && b >= utd_pkg::TRAIL_90)
                err = utd_pkg::ST_INVALID;
            if (err == utd_pkg::ST_OK)
            begin
                code_acc   = {code_acc[14:0], b[5:0]};
                trail_left = trail_left - 2'd1;
                if (trail_left == 2'd0)
                begin
                    if (total == 4)
                    begin
                        if (units_out + 2 > cap_eff)
                            err = utd_pkg::ST_OVERFLOW;
                        else
                        begin
                            v = code_acc - utd_pkg::SUPP_BASE;
                            expect_item({utd_pkg::HI_SURR, v[19:10]}, 1'b0, utd_pkg::ST_OK);
                            expect_item({utd_pkg::LO_SURR, v[9:0]}, 1'b0, utd_pkg::ST_OK);
                            units_out += 2;
                        end
                    end
                    else
                    begin
                        expect_item(code_acc[15:0], 1'b0, utd_pkg::ST_OK);
                        units_out++;
                    end
                end
            end
        end
        // End flag inside an open sequence
        if (err == utd_pkg::ST_OK && eom && trail_left != 2'd0)
            err = utd_pkg::ST_INVALID;
        if (eom)
        begin
            expect_item(16'h0000, 1'b1, err);
            clear_message();
        end
        else if (err != utd_pkg::ST_OK)
        begin
            dropping   = 1'b1;
            lead_byte  = {6'b0, err};
            trail_left = '0;
            code_acc   = '0;
        end
    endfunction

    // Build messages of random characters, most well formed, some damaged
    task automatic queue_messages(input int n_bytes);
        logic [7:0] msg[$];
        logic [7:0] lead;
        logic [7:0] sec_min;
        logic [7:0] sec_max;
        logic [7:0] odd_bytes[10] = '{8'h80, 8'hBF, 8'hC0, 8'hC1, 8'hF5,
                                      8'hFF, 8'h9F, 8'hA0, 8'h8F, 8'h90};
        int added;
        int n_chars;
        int kind;
        int n_trail;
        int pos;
        added = 0;
        while (added < n_bytes)
        begin
            msg.delete();
            n_chars = ($urandom_range(7, 0) == 0) ? $urandom_range(12, 7)
                                                  : $urandom_range(4, 1);
            for (int c = 0; c < n_chars; c++)
            begin
                kind = $urandom_range(9, 0);
                if (kind < 4)
                    msg.push_back(8'($urandom_range(127, 0)));
                else
                begin
                    if (kind < 6)
                    begin
                        lead    = 8'($urandom_range(8'hDF, utd_pkg::LEAD_MIN));
                        n_trail = 1;
                    end
                    else if (kind < 8)
                    begin
                        lead    = 8'($urandom_range(8'hEF, utd_pkg::LEAD3_MIN));
                        n_trail = 2;
                    end
                    else
                    begin
                        lead    = 8'($urandom_range(utd_pkg::LEAD_F4, utd_pkg::LEAD4_MIN));
                        n_trail = 3;
                    end
                    msg.push_back(lead);
                    // narrow the second byte after E0, ED, F0 and F4
                    sec_min = 8'h80;
                    sec_max = 8'hBF;
                    if (lead == utd_pkg::LEAD3_MIN)
                        sec_min = utd_pkg::TRAIL_A0;
                    else if (lead == utd_pkg::LEAD_ED)
                        sec_max = utd_pkg::TRAIL_A0 - 8'd1;
                    else if (lead == utd_pkg::LEAD4_MIN)
                        sec_min = utd_pkg::TRAIL_90;
                    else if (lead == utd_pkg::LEAD_F4)
                        sec_max = utd_pkg::TRAIL_90 - 8'd1;
                    msg.push_back(8'($urandom_range(sec_max, sec_min)));
                    for (int t = 1; t < n_trail; t++)
                        msg.push_back(8'($urandom_range(8'hBF, 8'h80)));
                end
            end
            if ($urandom_range(3, 0) == 0)
            begin
                pos = $urandom_range(msg.size() - 1, 0);
                case ($urandom_range(3, 0))
                    0: msg[pos] = 8'($urandom_range(255, 0));
                    1: msg = msg[0:pos];
                    2: msg.insert(pos, 8'($urandom_range(255, 0)));
                    default: msg[pos] = odd_bytes[$urandom_range(9, 0)];
                endcase
            end
            for (int k = 0; k < msg.size(); k++)
                push_request(msg[k], k == msg.size() - 1);
            added += msg.size();
        end
    endtask

    // Hold until every request is taken and every predicted item has come
    task automatic wait_drained();
        do @(negedge clk);
        while (bytes_taken != bytes_queued || pending_units.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(negedge clk)
    begin : drive
        logic [8:0] req;
        if (rst_n)
        begin
            if (!s_axis_tvalid || byte_accepted)
            begin
                if (byte_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    req = byte_queue.pop_front();
                    s_axis_tdata  <= req[7:0];
                    s_axis_tlast  <= req[8];
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : observe
        out_item_t want;
        out_item_t got;
        if (rst_n)
        begin
            byte_accepted = s_axis_tvalid && s_axis_tready;
            if (byte_accepted)
            begin
                decode_byte(s_axis_tdata, s_axis_tlast);
                bytes_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tuser[2:1], m_axis_tlast};
                if (pending_units.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, %s%h %s%b %s%0d %s%b",
                             $time, "got unit=", got.unit_word, "status=", got.is_status,
                             "code=", got.status_code, "last=", got.last);
                    error_count++;
                end
                else
                begin
                    want = pending_units.pop_front();
                    if (got.unit_word !== want.unit_word ||
                        got.is_status !== want.is_status ||
                        got.status_code !== want.status_code || got.last !== want.last)
                    begin
                        $display("%0t: mismatch, expected unit=%h status=%b code=%0d last=%b,",
                                 $time, want.unit_word, want.is_status, want.status_code,
                                 want.last);
                        $display("%0t:   got unit=%h status=%b code=%0d last=%b",
                                 $time, got.unit_word, got.is_status, got.status_code,
                                 got.last);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [8:0] directed[$];
        int cap;
        // {message_end, byte}: edge code points of each length, then each kind of invalid input
        directed = '{9'h000, 9'h07F, 9'h0DF, 9'h0BF, 9'h0ED, 9'h09F, 9'h0BF,
                     9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,
                     9'h080, 9'h141,
                     9'h1F5,
                     9'h0E0, 9'h19F,
                     9'h0ED, 9'h1A0,
                     9'h0F0, 9'h18F,
                     9'h0F4, 9'h190,
                     9'h0C2, 9'h1C0,
                     9'h0E1, 9'h180};
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b1;
        clear_message();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct  = 16;
        recv_stall_pct = 50;
        foreach (directed[i])
            push_request(directed[i][7:0], directed[i][8]);

        for (int ph = 1; ph <= 6; ph++)
        begin
            wait_drained();
            case (ph)
                1: cap = 0;
                2: cap = 65535;
                3: cap = 1;
                4: cap = 3;
                5: cap = $urandom_range(8, 2);
                default: cap = $urandom_range(65535, 0);
            endcase
            @(negedge clk);
            cfg_we    = 1'b1;
            cfg_wdata = 16'(cap);
            capacity  = cap;
            @(negedge clk);
            cfg_we = 1'b0;
            if (ph >= 5)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            else if (ph >= 3)
            begin
                send_idle_pct  = 50;
                recv_stall_pct = 16;
            end
            queue_messages(58);
        end

        wait_drained();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== utf8_to_utf16_decoder.f =====
src/utd_pkg.sv
src/utd_front.sv
src/utd_queue.sv
src/utd_back.sv
src/utf8_to_utf16_decoder.sv
dv/tb.sv
